FILE: rtl/vmd_pkg.sv
// Shared types, constants and register codes for the vibrato modulated delay.
package vmd_pkg;

	localparam int MAX_DELAY      = 1024;
	localparam int ADDR_W         = $clog2(MAX_DELAY);
	localparam int CLR_W          = ADDR_W + 1;
	localparam int COS_TABLE_BITS = 10;
	localparam int SAMPLE_W       = 16;
	localparam int BASE_W         = 10;
	localparam int PHASE_W        = 24;
	localparam int COUNT_W        = 20;
	localparam int CFG_DATA_W     = 24;
	localparam int QW             = 31;   // Q30 unsigned working width
	localparam int TAP_W          = BASE_W + 1;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);

	localparam logic [QW-1:0] Q_ONE = QW'(31'h4000_0000);
	localparam logic [QW-1:0] C1    = QW'(1686629713);
	localparam logic [QW-1:0] C3    = QW'(693598618);
	localparam logic [QW-1:0] C5    = QW'(85569306);
	localparam logic [QW-1:0] C7    = QW'(5026997);
	localparam logic [QW-1:0] C9    = QW'(172272);

	localparam logic [BASE_W-1:0]  BASE_DELAY_RST = BASE_W'(256);
	localparam logic [PHASE_W-1:0] PHASE_STEP_RST = PHASE_W'(1748);
	localparam logic [COUNT_W-1:0] WRAP_COUNT_RST = COUNT_W'(9120);

	typedef enum logic [1:0] {
		REG_BASE_DELAY,
		REG_PHASE_STEP,
		REG_WRAP_COUNT,
		REG_STEREO_ENABLE
	} reg_idx_t;

	typedef struct packed {
		logic [BASE_W-1:0]  base_delay;
		logic [PHASE_W-1:0] phase_step;
		logic [COUNT_W-1:0] wrap_count;
		logic               stereo_enable;
	} cfg_t;

	// sample beat travelling down the tap pipeline
	typedef struct packed {
		logic [ADDR_W-1:0]          wp;
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
	} front_item_t;

	// classified beat handed from front to back
	typedef struct packed {
		logic [ADDR_W-1:0]          wp;
		logic [ADDR_W-1:0]          rd;
		logic                       bypass;
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
	} entry_t;

endpackage

FILE: rtl/vmd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vmd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/vmd_queue.sv
// Short FIFO between the tap pipeline and the delay-line back end.
module vmd_queue
	import vmd_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	output logic   full,
	input  logic   pop,
	output entry_t pop_data,
	output logic   valid
);

	entry_t              slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q;
	logic [QUEUE_AW-1:0] rd_q;
	logic [QUEUE_AW:0]   cnt_q;

	assign full     = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign valid    = (cnt_q != '0);
	assign pop_data = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/vmd_front.sv
// Front end: accepts sample beats, runs the LFO and computes the modulated tap.
module vmd_front
	import vmd_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       hold,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] left_in,
	input  logic signed [SAMPLE_W-1:0] right_in,
	input  logic                       q_full,
	output logic                       q_push,
	output entry_t                     q_data
);

	localparam logic [COS_TABLE_BITS-1:0] HALF = COS_TABLE_BITS'(1) << (COS_TABLE_BITS - 1);

	logic [COUNT_W-1:0] cnt_q;
	logic [PHASE_W-1:0] phase_q;
	logic [ADDR_W-1:0]  wp_q;

	logic adv, accept;
	logic [COUNT_W-1:0]        cnt_inc;
	logic [PHASE_W-1:0]        phase_inc;
	logic [COS_TABLE_BITS-1:0] idx, j;
	logic [QW-1:0]             y_new;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	front_item_t it_s1, it_s2, it_s3, it_s4, it_s5, it_s6, it_s7, it_s8, it_s9;
	logic [QW-1:0] y_s1, y_s2, y_s3, y_s4, y_s5, y_s6;
	logic [QW-1:0] y2_s2, y2_s3, y2_s4, y2_s5;
	logic [QW-1:0] p_s3, p_s4, p_s5, p_s6;
	logic [QW-1:0] sn_s7, h_s8;
	logic [TAP_W-1:0] tap_s9;

	logic [2*QW-1:0]      m_y2, m_p3, m_p4, m_p5, m_p6, m_s, m_h;
	logic [BASE_W+QW-1:0] m_tap;
	logic [QW:0]          s_raw;
	logic [BASE_W-1:0]    tap_c;

	assign adv      = !(vld_s9 && q_full);
	assign in_stall = hold || !adv;
	assign accept   = in_valid && !in_stall;

	// raised-cosine index, folded about the half cycle
	assign idx   = phase_q[PHASE_W-1 -: COS_TABLE_BITS];
	assign j     = (idx <= HALF) ? idx : (~idx + 1'b1);
	assign y_new = {j, {(QW - COS_TABLE_BITS){1'b0}}};

	assign cnt_inc   = cnt_q + 1'b1;
	assign phase_inc = phase_q + cfg.phase_step;

	// sine polynomial (Horner), one product per stage
	assign m_y2  = {{QW{1'b0}}, y_s1} * {{QW{1'b0}}, y_s1};
	assign m_p3  = {{QW{1'b0}}, C9} * {{QW{1'b0}}, y2_s2};
	assign m_p4  = {{QW{1'b0}}, p_s3} * {{QW{1'b0}}, y2_s3};
	assign m_p5  = {{QW{1'b0}}, p_s4} * {{QW{1'b0}}, y2_s4};
	assign m_p6  = {{QW{1'b0}}, p_s5} * {{QW{1'b0}}, y2_s5};
	assign m_s   = {{QW{1'b0}}, p_s6} * {{QW{1'b0}}, y_s6};
	assign m_h   = {{QW{1'b0}}, sn_s7} * {{QW{1'b0}}, sn_s7};
	assign m_tap = {{QW{1'b0}}, cfg.base_delay} * {{BASE_W{1'b0}}, h_s8};
	assign s_raw = m_s[2*QW-1:QW-1];

	// tap clamp to base_delay-1, read address behind the write pointer
	always_comb begin
		tap_c = tap_s9[BASE_W-1:0];
		if (cfg.base_delay == '0) begin
			tap_c = '0;
		end else if (tap_s9 > {1'b0, cfg.base_delay - 1'b1}) begin
			tap_c = cfg.base_delay - 1'b1;
		end
	end

	assign q_push        = vld_s9 && !q_full;
	assign q_data.wp     = it_s9.wp;
	assign q_data.rd     = it_s9.wp - ADDR_W'(tap_c);
	assign q_data.bypass = (tap_c == '0);
	assign q_data.left   = it_s9.left;
	assign q_data.right  = it_s9.right;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			phase_q <= '0;
			wp_q    <= '0;
		end else if (accept) begin
			wp_q <= wp_q + 1'b1;
			if (cnt_inc >= cfg.wrap_count) begin
				cnt_q   <= '0;
				phase_q <= '0;
			end else begin
				cnt_q   <= cnt_inc;
				phase_q <= phase_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9} <= '0;
		end else if (adv) begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s1 <= '{wp: wp_q, left: left_in, right: right_in};
			y_s1  <= y_new;

			it_s2 <= it_s1;
			y_s2  <= y_s1;
			y2_s2 <= m_y2[2*QW-2:QW-1];

			it_s3 <= it_s2;
			y_s3  <= y_s2;
			y2_s3 <= y2_s2;
			p_s3  <= C7 - m_p3[2*QW-2:QW-1];

			it_s4 <= it_s3;
			y_s4  <= y_s3;
			y2_s4 <= y2_s3;
			p_s4  <= C5 - m_p4[2*QW-2:QW-1];

			it_s5 <= it_s4;
			y_s5  <= y_s4;
			y2_s5 <= y2_s4;
			p_s5  <= C3 - m_p5[2*QW-2:QW-1];

			it_s6 <= it_s5;
			y_s6  <= y_s5;
			p_s6  <= C1 - m_p6[2*QW-2:QW-1];

			it_s7 <= it_s6;
			sn_s7 <= (s_raw > {1'b0, Q_ONE}) ? Q_ONE : s_raw[QW-1:0];

			it_s8 <= it_s7;
			h_s8  <= m_h[2*QW-2:QW-1];

			it_s9  <= it_s8;
			tap_s9 <= m_tap[BASE_W+QW-1:QW-1];
		end
	end

endmodule

FILE: rtl/vmd_back.sv
// Back end: delay-line RAMs, clearing pass after reset and output register.
module vmd_back
	import vmd_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        stereo_enable,
	output logic                        clr_busy,
	input  logic                        q_valid,
	input  entry_t                      q_data,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [SAMPLE_W-1:0]  left_out,
	output logic signed [SAMPLE_W-1:0]  right_out
);

	logic [CLR_W-1:0]    clr_q;
	logic                inflight_q;
	logic                byp_s1;
	logic [SAMPLE_W-1:0] left_s1, right_s1;
	logic                out_vld_q;
	logic [SAMPLE_W-1:0] left_q, right_q;

	logic                we_l, we_r;
	logic [ADDR_W-1:0]   waddr;
	logic [SAMPLE_W-1:0] wdata_l, wdata_r, rdata_l, rdata_r;
	logic                out_take;

	assign clr_busy = !clr_q[CLR_W-1];
	assign out_take = out_vld_q && !out_stall;
	// one read outstanding; issue only when the output slot is free at landing
	assign q_pop    = q_valid && !clr_busy && !inflight_q && (!out_vld_q || !out_stall);

	assign we_l    = clr_busy || q_pop;
	assign we_r    = clr_busy || (q_pop && stereo_enable);
	assign waddr   = clr_busy ? clr_q[ADDR_W-1:0] : q_data.wp;
	assign wdata_l = clr_busy ? '0 : q_data.left;
	assign wdata_r = clr_busy ? '0 : q_data.right;

	vmd_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_DELAY)) u_left_line (
		.clk   (clk),
		.we    (we_l),
		.waddr (waddr),
		.wdata (wdata_l),
		.raddr (q_data.rd),
		.rdata (rdata_l)
	);

	vmd_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_DELAY)) u_right_line (
		.clk   (clk),
		.we    (we_r),
		.waddr (waddr),
		.wdata (wdata_r),
		.raddr (q_data.rd),
		.rdata (rdata_r)
	);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			byp_s1   <= q_data.bypass;
			left_s1  <= q_data.left;
			right_s1 <= q_data.right;
		end
		if (inflight_q) begin
			left_q  <= byp_s1 ? left_s1 : rdata_l;
			right_q <= !stereo_enable ? '0 : (byp_s1 ? right_s1 : rdata_r);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			inflight_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (clr_busy) begin
				clr_q <= clr_q + 1'b1;
			end
			inflight_q <= q_pop;
			if (inflight_q) begin
				out_vld_q <= 1'b1;
			end else if (out_take) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign left_out  = left_q;
	assign right_out = right_q;

`ifndef SYNTHESIS
	a_single_read: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !inflight_q)
		else $error("beat issued while a read is outstanding");

	a_no_issue_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !q_pop)
		else $error("beat issued during clearing pass");

	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q |-> (!out_vld_q || !out_stall))
		else $error("read data lands on an untaken result");
`endif

endmodule

FILE: rtl/vibrato_modulated_delay.sv
// Top level of the stereo vibrato: configuration registers, front end, queue, back end.
// Stereo vibrato on Q1.15 samples. Each input beat writes left and right into
// 1024-entry delay lines and returns the samples base_delay*(1-cos)/2 behind
// the newest, clamped to base_delay-1; tap zero returns the sample just
// written. A 24-bit LFO accumulator, cut to its top 10 bits, drives a
// fixed-point raised cosine; the sample counter and phase restart from zero
// when the counter reaches wrap_count. In mono mode the right line is left
// untouched and right_out is zero. After reset a clearing pass zeroes both
// delay lines, during which in_stall is held high; register writes are
// taken throughout. The back end keeps one delay-line read outstanding at a
// time (registered RAM read, then the output register), so it takes no new
// beat from the queue until the last read has landed. The front end accepts
// a beat each cycle, unless stalled, into a nine-stage tap pipeline (one
// multiplier in each stage after the first) that feeds a four-entry queue,
// so bursts are absorbed. Registers take effect from the next beat and must
// be written only while the block is idle.
module vibrato_modulated_delay
	import vmd_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration write port
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	// input channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [SAMPLE_W-1:0]  left_in,
	input  logic signed [SAMPLE_W-1:0]  right_in,
	// output channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [SAMPLE_W-1:0]  left_out,
	output logic signed [SAMPLE_W-1:0]  right_out
);

	cfg_t   cfg_q;
	logic   clr_busy;
	logic   q_push, q_full, q_pop, q_valid;
	entry_t q_in, q_out;

	// register file; the four register codes cover every index value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_delay    <= BASE_DELAY_RST;
			cfg_q.phase_step    <= PHASE_STEP_RST;
			cfg_q.wrap_count    <= WRAP_COUNT_RST;
			cfg_q.stereo_enable <= 1'b1;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_BASE_DELAY:    cfg_q.base_delay    <= cfg_data[BASE_W-1:0];
				REG_PHASE_STEP:    cfg_q.phase_step    <= cfg_data[PHASE_W-1:0];
				REG_WRAP_COUNT:    cfg_q.wrap_count    <= cfg_data[COUNT_W-1:0];
				REG_STEREO_ENABLE: cfg_q.stereo_enable <= cfg_data[0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	// front: LFO, raised cosine and tap, one beat per cycle unless stalled
	vmd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.hold     (clr_busy),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.left_in  (left_in),
		.right_in (right_in),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_in)
	);

	// decouples the tap pipeline from the delay-line port
	vmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.valid     (q_valid)
	);

	// back: delay-line write and read, result register
	vmd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.stereo_enable (cfg_q.stereo_enable),
		.clr_busy      (clr_busy),
		.q_valid       (q_valid),
		.q_data        (q_out),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.left_out      (left_out),
		.right_out     (right_out)
	);

endmodule
